>>> hdl/spbp_pkg.sv
// Shared constants, types and codes for the serpentine panel board packer.
// Used by the controller, the datapath and the top level; depends on nothing.
package spbp_pkg;

	localparam int BOARD_SIDE    = 4;
	localparam int BOARDS_ACROSS = 3;
	localparam int BOARDS_DOWN   = 3;

	localparam int FB_ROWS     = BOARDS_DOWN * BOARD_SIDE;
	localparam int FB_COLS     = BOARDS_ACROSS * BOARD_SIDE;
	localparam int BOARD_COUNT = BOARDS_ACROSS * BOARDS_DOWN;
	localparam int DEPTH       = FB_ROWS * FB_COLS;

	localparam int ROW_W  = (FB_ROWS > 1) ? $clog2(FB_ROWS) : 1;
	localparam int COL_W  = (FB_COLS > 1) ? $clog2(FB_COLS) : 1;
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int SIDE_W = (BOARD_SIDE > 1) ? $clog2(BOARD_SIDE) : 1;
	localparam int BROW_W = (BOARDS_DOWN > 1) ? $clog2(BOARDS_DOWN) : 1;
	localparam int BPOS_W = (BOARDS_ACROSS > 1) ? $clog2(BOARDS_ACROSS) : 1;

	localparam int LEVEL_W = 12;
	localparam int PIXEL_W = 3 * LEVEL_W;

	localparam logic [1:0] FACE_NORTH = 2'd0;
	localparam logic [1:0] FACE_EAST  = 2'd1;
	localparam logic [1:0] FACE_SOUTH = 2'd2;

	localparam logic [1:0] SEL_ZERO  = 2'd0;
	localparam logic [1:0] SEL_BLUE  = 2'd1;
	localparam logic [1:0] SEL_RED   = 2'd2;
	localparam logic [1:0] SEL_GREEN = 2'd3;

	typedef struct packed {
		logic       load;
		logic       decode;
		logic       store;
		logic       read;
		logic       emit;
		logic [1:0] sel;
		logic       last;
		logic       status;
	} spbp_cmd_t;

	typedef struct packed {
		logic is_write;
		logic write_ok;
		logic board_ok;
		logic last_pixel;
	} spbp_stat_t;

endpackage

>>> hdl/spbp_ctl.sv
// Controller state machine of the serpentine panel board packer.
// Depends on spbp_pkg for the command and status structs and codes.
module spbp_ctl
	import spbp_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  spbp_stat_t stat,
	output spbp_cmd_t  cmd
);

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_DECODE = 3'd1;
	localparam logic [2:0] ST_READ   = 3'd2;
	localparam logic [2:0] ST_CH0    = 3'd3;
	localparam logic [2:0] ST_CH1    = 3'd4;
	localparam logic [2:0] ST_CH2    = 3'd5;

	logic [2:0] state_q;
	logic [2:0] state_d;

	assign busy = (state_q != ST_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = ST_DECODE;
				end
			end
			ST_DECODE: begin
				cmd.decode = 1'b1;
				if (stat.is_write) begin
					cmd.store  = stat.write_ok;
					cmd.emit   = 1'b1;
					cmd.sel    = SEL_ZERO;
					cmd.last   = 1'b1;
					cmd.status = !stat.write_ok;
					state_d    = ST_IDLE;
				end else if (!stat.board_ok) begin
					cmd.emit   = 1'b1;
					cmd.sel    = SEL_ZERO;
					cmd.last   = 1'b1;
					cmd.status = 1'b1;
					state_d    = ST_IDLE;
				end else begin
					state_d = ST_READ;
				end
			end
			ST_READ: begin
				cmd.read = 1'b1;
				state_d  = ST_CH0;
			end
			ST_CH0: begin
				cmd.emit = 1'b1;
				cmd.sel  = SEL_BLUE;
				state_d  = ST_CH1;
			end
			ST_CH1: begin
				cmd.emit = 1'b1;
				cmd.sel  = SEL_RED;
				state_d  = ST_CH2;
			end
			ST_CH2: begin
				cmd.emit = 1'b1;
				cmd.sel  = SEL_GREEN;
				cmd.last = stat.last_pixel;
				if (stat.last_pixel) begin
					state_d = ST_IDLE;
				end else begin
					cmd.read = 1'b1;
					state_d  = ST_CH0;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

>>> hdl/spbp_dp.sv
// Datapath of the serpentine panel board packer: input registers, board decode,
// scan counters, pixel memory with valid bits, and the result register. Uses spbp_pkg.
module spbp_dp
	import spbp_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               operation,
	input  logic [3:0]         board_number,
	input  logic [5:0]         pixel_row,
	input  logic [5:0]         pixel_column,
	input  logic [LEVEL_W-1:0] red_level,
	input  logic [LEVEL_W-1:0] green_level,
	input  logic [LEVEL_W-1:0] blue_level,
	input  spbp_cmd_t          cmd,
	output spbp_stat_t         stat,
	output logic               strobe,
	output logic [LEVEL_W-1:0] channel_value,
	output logic               last_of_run,
	output logic               status
);

	localparam logic [SIDE_W-1:0] SIDE_MAX = SIDE_W'(BOARD_SIDE - 1);

	logic               op_q;
	logic [3:0]         board_q;
	logic [5:0]         row_q;
	logic [5:0]         col_q;
	logic [LEVEL_W-1:0] red_q;
	logic [LEVEL_W-1:0] green_q;
	logic [LEVEL_W-1:0] blue_q;

	logic [ROW_W-1:0]   ro_q;
	logic [COL_W-1:0]   co_q;
	logic [1:0]         face_q;
	logic [SIDE_W-1:0]  a_q;
	logic [SIDE_W-1:0]  b_q;
	logic               last_px_q;

	logic [BROW_W-1:0]  brow;
	logic [BPOS_W-1:0]  bpos;
	logic [BPOS_W-1:0]  bcol;
	logic [ROW_W-1:0]   ro_d;
	logic [COL_W-1:0]   co_d;
	logic [1:0]         face_d;

	logic [SIDE_W-1:0]  lr;
	logic [SIDE_W-1:0]  lc;
	logic [ROW_W-1:0]   rd_row;
	logic [COL_W-1:0]   rd_col;
	logic [ADDR_W-1:0]  rd_addr;
	logic [ADDR_W-1:0]  wr_addr;
	logic               at_last;

	logic [PIXEL_W-1:0] mem [DEPTH];
	logic [DEPTH-1:0]   valid_q;
	logic [PIXEL_W-1:0] rdata_q;
	logic               rvalid_q;
	logic [PIXEL_W-1:0] pixel;

	logic               strobe_q;
	logic [LEVEL_W-1:0] value_q;
	logic               last_q;
	logic               status_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q    <= operation;
			board_q <= board_number;
			row_q   <= pixel_row;
			col_q   <= pixel_column;
			red_q   <= red_level;
			green_q <= green_level;
			blue_q  <= blue_level;
		end
	end

	assign stat.is_write   = !op_q;
	assign stat.write_ok   = (row_q < 6'(FB_ROWS)) && (col_q < 6'(FB_COLS));
	assign stat.board_ok   = ({1'b0, board_q} < 5'(BOARD_COUNT));
	assign stat.last_pixel = last_px_q;

	always_comb begin
		brow = '0;
		for (int k = 1; k < BOARDS_DOWN; k++) begin
			if ({1'b0, board_q} >= 5'(k * BOARDS_ACROSS)) begin
				brow = BROW_W'(k);
			end
		end
		bpos = BPOS_W'(int'(board_q) - int'(brow) * BOARDS_ACROSS);
		bcol = brow[0] ? BPOS_W'(BOARDS_ACROSS - 1 - int'(bpos)) : bpos;
		ro_d = ROW_W'(int'(brow) * BOARD_SIDE);
		co_d = COL_W'(int'(bcol) * BOARD_SIDE);
		if (board_q == 4'd0) begin
			face_d = FACE_NORTH;
		end else if (bpos == '0) begin
			face_d = FACE_EAST;
		end else if (brow[0]) begin
			face_d = FACE_SOUTH;
		end else begin
			face_d = FACE_NORTH;
		end
	end

	always_comb begin
		case (face_q)
			FACE_EAST: begin
				lr = SIDE_MAX - b_q;
				lc = SIDE_MAX - a_q;
			end
			FACE_SOUTH: begin
				lr = SIDE_MAX - a_q;
				lc = b_q;
			end
			default: begin
				lr = a_q;
				lc = SIDE_MAX - b_q;
			end
		endcase
		rd_row  = ro_q + ROW_W'(lr);
		rd_col  = co_q + COL_W'(lc);
		rd_addr = ADDR_W'(int'(rd_row) * FB_COLS + int'(rd_col));
		wr_addr = ADDR_W'(int'(row_q[ROW_W-1:0]) * FB_COLS + int'(col_q[COL_W-1:0]));
		at_last = (a_q == SIDE_MAX) && (b_q == SIDE_MAX);
	end

	always_ff @(posedge clk) begin
		if (cmd.decode) begin
			ro_q   <= ro_d;
			co_q   <= co_d;
			face_q <= face_d;
			a_q    <= '0;
			b_q    <= '0;
		end else if (cmd.read) begin
			last_px_q <= at_last;
			if (b_q == SIDE_MAX) begin
				b_q <= '0;
				a_q <= a_q + 1'b1;
			end else begin
				b_q <= b_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.store) begin
			mem[wr_addr] <= {red_q, green_q, blue_q};
		end
		if (cmd.read) begin
			rdata_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			rvalid_q <= 1'b0;
		end else begin
			if (cmd.store) begin
				valid_q[wr_addr] <= 1'b1;
			end
			if (cmd.read) begin
				rvalid_q <= valid_q[rd_addr];
			end
		end
	end

	assign pixel = rvalid_q ? rdata_q : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= cmd.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			last_q   <= cmd.last;
			status_q <= cmd.status;
			case (cmd.sel)
				SEL_BLUE:  value_q <= pixel[LEVEL_W-1:0];
				SEL_RED:   value_q <= pixel[PIXEL_W-1:2*LEVEL_W];
				SEL_GREEN: value_q <= pixel[2*LEVEL_W-1:LEVEL_W];
				default:   value_q <= '0;
			endcase
		end
	end

	assign strobe        = strobe_q;
	assign channel_value = value_q;
	assign last_of_run   = last_q;
	assign status        = status_q;

endmodule

>>> hdl/serpentine_panel_board_packer_top.sv
// Top level of the serpentine panel board packer.
// Instantiates spbp_ctl and spbp_dp; uses spbp_pkg.

// A command is taken when start is high and busy is low. A pixel write gives a
// single result. A pack of a board in range decodes the board, then reads the
// pixel memory once per pixel, and each pixel gives three results, blue, red and
// green in that order. A rejected pack gives a single result with status high.
// The next command can be taken while the last result is shown.
// Every result is shown for exactly one cycle with strobe high and the receiver
// cannot stall it, so it must capture each transfer on the cycle it appears. The
// framebuffer reads as all zero after reset without any clearing pass.
module serpentine_panel_board_packer_top
	import spbp_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic               operation,
	input  logic [3:0]         board_number,
	input  logic [5:0]         pixel_row,
	input  logic [5:0]         pixel_column,
	input  logic [LEVEL_W-1:0] red_level,
	input  logic [LEVEL_W-1:0] green_level,
	input  logic [LEVEL_W-1:0] blue_level,
	output logic               strobe,
	output logic [LEVEL_W-1:0] channel_value,
	output logic               last_of_run,
	output logic               status
);

	spbp_cmd_t  cmd;
	spbp_stat_t stat;

	spbp_ctl u_ctl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.stat   (stat),
		.cmd    (cmd)
	);

	spbp_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.operation     (operation),
		.board_number  (board_number),
		.pixel_row     (pixel_row),
		.pixel_column  (pixel_column),
		.red_level     (red_level),
		.green_level   (green_level),
		.blue_level    (blue_level),
		.cmd           (cmd),
		.stat          (stat),
		.strobe        (strobe),
		.channel_value (channel_value),
		.last_of_run   (last_of_run),
		.status        (status)
	);

endmodule
